// ===== rtl/core/uib_pkg.sv =====
// Shared types and constants of the UART interrupt buffer engine.
// No dependencies; the core and the checker refer to it by scoped names.
`default_nettype none

package uib_pkg;

  localparam int unsigned TX_DEPTH_DEF = 64;
  localparam int unsigned RX_DEPTH_DEF = 64;
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned OUT_TDATA_W  = 16;

  localparam logic [LEN_W-1:0] FRAME_LIMIT_RST = 7'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TX_QUEUE = 2'd0,
    ACT_RX_BYTE  = 2'd1,
    ACT_RX_IDLE  = 2'd2,
    ACT_TX_EMPTY = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUEUED  = 3'd0,
    KIND_REJECT  = 3'd1,
    KIND_TX_BYTE = 3'd2,
    KIND_TX_DONE = 3'd3,
    KIND_RX_BYTE = 3'd4,
    KIND_STORED  = 3'd5,
    KIND_NOTHING = 3'd6
  } kind_e;

endpackage

`default_nettype wire

// ===== rtl/core/uib_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the transmit FIFO and the receive frame store.
`default_nettype none

module uib_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/uart_irq_buffer_engine_core.sv =====
// Top level of the UART interrupt buffer engine: event sequencer, FIFO and frame store.
// Depends on uib_pkg and uib_ram.
//
// Each input word is one UART event: tuser carries the action, tdata the byte.
// Queue, rejected and idle events, and receive bytes that do not end a frame, register
// their result word at once. A transmit pop passes through ST_TX_OUT because the byte
// comes out of the FIFO RAM through its registered read port. A frame flush passes
// through ST_FL_RD and then ST_FL_OUT: the sequencer walks the frame store through its
// single read port, one byte per cycle while the output is taken, and emits each byte
// as an output word with tlast on the final one. The input stays not ready while a
// flush or pop is in progress and while an output word is waiting without being taken.
// Both stores need no clearing after reset, since only written entries are ever read.
`default_nettype none

module uart_irq_buffer_engine_core #(
  parameter int unsigned TX_DEPTH = uib_pkg::TX_DEPTH_DEF,
  parameter int unsigned RX_DEPTH = uib_pkg::RX_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [uib_pkg::LEN_W-1:0]           cfg_wdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [uib_pkg::DATA_W-1:0]          s_axis_tdata_i,  // [7:0] data_in
  input  wire logic [uib_pkg::ACTION_W-1:0]        s_axis_tuser_i,  // [1:0] action
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic      [uib_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,  // [7:0] data_out,
                                                                   // [14:8] frame_len
  output logic      [uib_pkg::KIND_W-1:0]          m_axis_tuser_o,  // [2:0] kind
  output logic                                     m_axis_tlast_o
);

  localparam int unsigned TPW  = $clog2(TX_DEPTH);
  localparam int unsigned TCW  = $clog2(TX_DEPTH + 1);
  localparam int unsigned RAW  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned RCW  = $clog2(RX_DEPTH + 1);
  localparam int unsigned DW   = uib_pkg::DATA_W;
  localparam int unsigned LW   = uib_pkg::LEN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TX_OUT,
    ST_FL_RD,
    ST_FL_OUT
  } state_e;

  state_e                state_q, state_d;
  logic [TPW-1:0]        tx_wptr_q, tx_wptr_d;
  logic [TPW-1:0]        tx_rptr_q, tx_rptr_d;
  logic [TCW-1:0]        tx_cnt_q, tx_cnt_d;
  logic                  tx_irq_q, tx_irq_d;
  logic [RCW-1:0]        rx_cnt_q, rx_cnt_d;
  logic [RCW-1:0]        fl_len_q, fl_len_d;
  logic [RAW-1:0]        fl_idx_q, fl_idx_d;
  logic [LW-1:0]         limit_q;

  logic                  m_valid_q, m_valid_d;
  uib_pkg::kind_e        m_kind_q, m_kind_d;
  logic [DW-1:0]         m_data_q, m_data_d;
  logic [LW-1:0]         m_len_q, m_len_d;
  logic                  m_last_q, m_last_d;

  logic                  out_free;
  logic                  in_fire;
  logic [LW-1:0]         eff_limit;
  logic [RCW-1:0]        rx_next;
  logic                  fl_last;

  logic                  tx_we, tx_re;
  logic [DW-1:0]         tx_rdata;
  logic                  rx_we, rx_re;
  logic [RAW-1:0]        rx_raddr;
  logic [DW-1:0]         rx_rdata;

  uib_ram #(.WIDTH(DW), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_wptr_q),
    .wdata_i (s_axis_tdata_i),
    .re_i    (tx_re),
    .raddr_i (tx_rptr_q),
    .rdata_o (tx_rdata)
  );

  uib_ram #(.WIDTH(DW), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_cnt_q[RAW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign rx_next         = rx_cnt_q + RCW'(1);
  assign fl_last         = (RCW'(fl_idx_q) == (fl_len_q - RCW'(1)));

  always_comb begin
    if (limit_q == '0) begin
      eff_limit = LW'(1);
    end else if (limit_q > LW'(RX_DEPTH)) begin
      eff_limit = LW'(RX_DEPTH);
    end else begin
      eff_limit = limit_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    tx_wptr_d = tx_wptr_q;
    tx_rptr_d = tx_rptr_q;
    tx_cnt_d  = tx_cnt_q;
    tx_irq_d  = tx_irq_q;
    rx_cnt_d  = rx_cnt_q;
    fl_len_d  = fl_len_q;
    fl_idx_d  = fl_idx_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_kind_d  = m_kind_q;
    m_data_d  = m_data_q;
    m_len_d   = m_len_q;
    m_last_d  = m_last_q;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    rx_raddr  = fl_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          m_valid_d = 1'b1;
          m_kind_d  = uib_pkg::KIND_NOTHING;
          m_data_d  = '0;
          m_len_d   = '0;
          m_last_d  = 1'b1;
          unique case (uib_pkg::action_e'(s_axis_tuser_i))
            uib_pkg::ACT_TX_QUEUE: begin
              if (tx_cnt_q == TCW'(TX_DEPTH)) begin
                m_kind_d = uib_pkg::KIND_REJECT;
              end else begin
                tx_we     = 1'b1;
                tx_wptr_d = (tx_wptr_q == TPW'(TX_DEPTH - 1)) ? '0 : tx_wptr_q + TPW'(1);
                tx_cnt_d  = tx_cnt_q + TCW'(1);
                tx_irq_d  = 1'b1;
                m_kind_d  = uib_pkg::KIND_QUEUED;
              end
            end
            uib_pkg::ACT_RX_BYTE: begin
              rx_we = 1'b1;
              if (LW'(rx_next) >= eff_limit) begin
                m_valid_d = 1'b0;
                fl_len_d  = rx_next;
                fl_idx_d  = '0;
                rx_cnt_d  = '0;
                state_d   = ST_FL_RD;
              end else begin
                rx_cnt_d = rx_next;
                m_kind_d = uib_pkg::KIND_STORED;
              end
            end
            uib_pkg::ACT_RX_IDLE: begin
              if (rx_cnt_q != '0) begin
                m_valid_d = 1'b0;
                fl_len_d  = rx_cnt_q;
                fl_idx_d  = '0;
                rx_cnt_d  = '0;
                state_d   = ST_FL_RD;
              end
            end
            uib_pkg::ACT_TX_EMPTY: begin
              if (tx_irq_q) begin
                if (tx_cnt_q != '0) begin
                  m_valid_d = 1'b0;
                  tx_re     = 1'b1;
                  tx_cnt_d  = tx_cnt_q - TCW'(1);
                  if (tx_cnt_q == TCW'(1)) begin
                    tx_rptr_d = '0;
                    tx_wptr_d = '0;
                  end else begin
                    tx_rptr_d = (tx_rptr_q == TPW'(TX_DEPTH - 1)) ? '0
                                                                  : tx_rptr_q + TPW'(1);
                  end
                  state_d = ST_TX_OUT;
                end else begin
                  tx_irq_d = 1'b0;
                  m_kind_d = uib_pkg::KIND_TX_DONE;
                end
              end
            end
            default: begin
              m_kind_d = uib_pkg::KIND_NOTHING;
            end
          endcase
        end
      end
      ST_TX_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = uib_pkg::KIND_TX_BYTE;
          m_data_d  = tx_rdata;
          m_len_d   = '0;
          m_last_d  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_FL_RD: begin
        rx_re   = 1'b1;
        state_d = ST_FL_OUT;
      end
      ST_FL_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = uib_pkg::KIND_RX_BYTE;
          m_data_d  = rx_rdata;
          m_len_d   = LW'(fl_len_q);
          m_last_d  = fl_last;
          if (fl_last) begin
            state_d = ST_IDLE;
          end else begin
            rx_re    = 1'b1;
            rx_raddr = fl_idx_q + RAW'(1);
            fl_idx_d = fl_idx_q + RAW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tx_wptr_q <= '0;
      tx_rptr_q <= '0;
      tx_cnt_q  <= '0;
      tx_irq_q  <= 1'b0;
      rx_cnt_q  <= '0;
      fl_len_q  <= '0;
      fl_idx_q  <= '0;
      limit_q   <= uib_pkg::FRAME_LIMIT_RST;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tx_wptr_q <= tx_wptr_d;
      tx_rptr_q <= tx_rptr_d;
      tx_cnt_q  <= tx_cnt_d;
      tx_irq_q  <= tx_irq_d;
      rx_cnt_q  <= rx_cnt_d;
      fl_len_q  <= fl_len_d;
      fl_idx_q  <= fl_idx_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_kind_q <= m_kind_d;
    m_data_q <= m_data_d;
    m_len_q  <= m_len_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_len_q, m_data_q};
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/uib_checker.sv =====
// Port-level checks of the UART interrupt buffer engine, bound to its top level.
// Depends on uib_pkg and uart_irq_buffer_engine_core.
`default_nettype none

module uib_checker #(
  parameter int unsigned RX_DEPTH = uib_pkg::RX_DEPTH_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tready_o,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [uib_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [uib_pkg::KIND_W-1:0]      m_axis_tuser_o,
  input wire logic                            m_axis_tlast_o
);

  localparam int unsigned LW = uib_pkg::LEN_W;

  // A stalled output word must hold its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // No new event is taken while an output word is stuck.
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  // Words other than frame bytes are single results with no frame length and, but for transmit bytes, a zero data byte.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != uib_pkg::KIND_RX_BYTE) |->
      m_axis_tlast_o && (m_axis_tdata_o[15:8] == '0)
      && ((m_axis_tuser_o == uib_pkg::KIND_TX_BYTE) || (m_axis_tdata_o[7:0] == '0)))
    else $error("malformed single result");

  // A frame byte carries a frame length within the store depth.
  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == uib_pkg::KIND_RX_BYTE) |->
      (m_axis_tdata_o[14:8] != '0) && (m_axis_tdata_o[14:8] <= LW'(RX_DEPTH)))
    else $error("frame length out of range");

  // The output is idle while reset is applied.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind uart_irq_buffer_engine_core uib_checker #(
  .RX_DEPTH(RX_DEPTH)
) u_uib_checker (.*);

`default_nettype wire
